/* rtl/pfk_pkg.sv */
// ----------------------------------------------------------------------------
// pfk_pkg
// Shared types and constants for the planar three-link forward kinematics
// unit: word layouts, fixed-point formats and the cordic angle constants.
// ----------------------------------------------------------------------------
package pfk_pkg;

  localparam int ROTATION_STEPS = 16;
  localparam int STEP_W         = $clog2(ROTATION_STEPS);
  localparam int LINKS          = 3;

  localparam int ANG_W   = 16;
  localparam int LEN_W   = 16;
  localparam int OUT_W   = 20;
  localparam int SUM_W   = ANG_W + 2;
  localparam int THETA_W = 35;
  localparam int ZW      = 31;
  localparam int CW      = 35;
  localparam int GAIN_W  = 30;
  localparam int ANG_SHIFT  = 15;
  localparam int GAIN_SHIFT = 14;

  typedef logic signed [THETA_W-1:0] theta_t;
  typedef logic signed [ZW-1:0]      angle_t;
  typedef logic signed [CW-1:0]      coord_t;
  typedef logic [LEN_W-1:0]          len_t;
  typedef logic [STEP_W-1:0]         step_t;
  typedef logic [1:0]                cfg_index_t;

  localparam cfg_index_t REG_FIRST_LINK  = 2'd0;
  localparam cfg_index_t REG_SECOND_LINK = 2'd1;
  localparam cfg_index_t REG_TOOL_LINK   = 2'd2;

  localparam len_t FIRST_LINK_RESET  = 16'd16384;
  localparam len_t SECOND_LINK_RESET = 16'd8192;
  localparam len_t TOOL_LINK_RESET   = 16'd4096;

  // angles in q.28
  localparam theta_t PI_Q28      = theta_t'(843314857);
  localparam theta_t TWO_PI_Q28  = theta_t'(1686629714);
  localparam theta_t HALF_PI_Q28 = theta_t'(421657428);

  // cordic gain in q.30
  localparam logic [GAIN_W-1:0] GAIN_Q30 = GAIN_W'(652032874);

  // atan(2^-i) in q.28
  localparam angle_t ATAN_Q28 [24] = '{
    angle_t'(210828714), angle_t'(124459457), angle_t'(65760959),
    angle_t'(33381290),  angle_t'(16755422),  angle_t'(8385879),
    angle_t'(4193963),   angle_t'(2097109),   angle_t'(1048571),
    angle_t'(524287),    angle_t'(262144),    angle_t'(131072),
    angle_t'(65536),     angle_t'(32768),     angle_t'(16384),
    angle_t'(8192),      angle_t'(4096),      angle_t'(2048),
    angle_t'(1024),      angle_t'(512),       angle_t'(256),
    angle_t'(128),       angle_t'(64),        angle_t'(32)
  };

  typedef struct packed {
    logic signed [ANG_W-1:0] first_joint_angle;
    logic signed [ANG_W-1:0] second_joint_angle;
    logic signed [ANG_W-1:0] third_joint_angle;
  } joint_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] tip_x;
    logic signed [OUT_W-1:0] tip_y;
  } tip_word_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    angle_t z;
    logic   neg;
  } vec_t;

  typedef vec_t [LINKS-1:0] vec3_t;

endpackage

/* rtl/pfk_prep.sv */
// ----------------------------------------------------------------------------
// pfk_prep
// Front end: absolute link angles, wrap into (-pi, pi], fold into the
// cordic range and scale each link length by the cordic gain.
// ----------------------------------------------------------------------------
module pfk_prep (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_vld,
  input  pfk_pkg::joint_word_t                       joints,
  input  pfk_pkg::len_t [pfk_pkg::LINKS-1:0]         lens,
  output logic                                       out_vld,
  output pfk_pkg::vec3_t                             vec
);

  localparam int PROD_W = pfk_pkg::LEN_W + pfk_pkg::GAIN_W;

  logic [2:0] vld;
  pfk_pkg::theta_t [pfk_pkg::LINKS-1:0] th_abs, th_abs_next;
  pfk_pkg::theta_t [pfk_pkg::LINKS-1:0] th_wrap1, th_wrap1_next;
  pfk_pkg::theta_t [pfk_pkg::LINKS-1:0] th_wrap2, th_wrap2_next;
  pfk_pkg::vec3_t vec_next;

  function automatic pfk_pkg::theta_t wrap_step(input pfk_pkg::theta_t th);
    pfk_pkg::theta_t r;
    r = th;
    if (th > pfk_pkg::PI_Q28) begin
      r = th - pfk_pkg::TWO_PI_Q28;
    end else if (th <= -pfk_pkg::PI_Q28) begin
      r = th + pfk_pkg::TWO_PI_Q28;
    end
    return r;
  endfunction

  // joint sums
  always_comb begin
    logic signed [pfk_pkg::SUM_W-1:0] s1, s2, s3;
    s1 = pfk_pkg::SUM_W'(joints.first_joint_angle);
    s2 = s1 + pfk_pkg::SUM_W'(joints.second_joint_angle);
    s3 = s2 + pfk_pkg::SUM_W'(joints.third_joint_angle);
    th_abs_next[0] = pfk_pkg::theta_t'(s1) <<< pfk_pkg::ANG_SHIFT;
    th_abs_next[1] = pfk_pkg::theta_t'(s2) <<< pfk_pkg::ANG_SHIFT;
    th_abs_next[2] = pfk_pkg::theta_t'(s3) <<< pfk_pkg::ANG_SHIFT;
  end

  // two wrap passes cover the full input range
  always_comb begin
    for (int k = 0; k < pfk_pkg::LINKS; k++) begin
      th_wrap1_next[k] = wrap_step(th_abs[k]);
      th_wrap2_next[k] = wrap_step(th_wrap1[k]);
    end
  end

  // fold to +-pi/2 and start vector
  always_comb begin
    pfk_pkg::theta_t th;
    logic            neg;
    logic [PROD_W-1:0] prod;
    for (int k = 0; k < pfk_pkg::LINKS; k++) begin
      th  = th_wrap2[k];
      neg = 1'b0;
      if (th > pfk_pkg::HALF_PI_Q28) begin
        th  = th - pfk_pkg::PI_Q28;
        neg = 1'b1;
      end else if (th < -pfk_pkg::HALF_PI_Q28) begin
        th  = th + pfk_pkg::PI_Q28;
        neg = 1'b1;
      end
      prod = PROD_W'(lens[k]) * PROD_W'(pfk_pkg::GAIN_Q30);
      vec_next[k].x   = pfk_pkg::CW'(prod[PROD_W-1:pfk_pkg::GAIN_SHIFT]);
      vec_next[k].y   = '0;
      vec_next[k].z   = th[pfk_pkg::ZW-1:0];
      vec_next[k].neg = neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else begin
      vld     <= {vld[1:0], in_vld};
      out_vld <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    th_abs   <= th_abs_next;
    th_wrap1 <= th_wrap1_next;
    th_wrap2 <= th_wrap2_next;
    vec      <= vec_next;
  end

endmodule

/* rtl/pfk_cell.sv */
// ----------------------------------------------------------------------------
// pfk_cell
// One cordic micro-rotation for all three link vectors, registered.
// ----------------------------------------------------------------------------
module pfk_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  pfk_pkg::step_t        step,
  input  pfk_pkg::angle_t       atan,
  input  logic                  in_vld,
  input  pfk_pkg::vec3_t        vin,
  output logic                  out_vld,
  output pfk_pkg::vec3_t        vout
);

  pfk_pkg::vec3_t vout_next;

  always_comb begin
    pfk_pkg::coord_t dx, dy;
    for (int k = 0; k < pfk_pkg::LINKS; k++) begin
      dx = vin[k].y >>> step;
      dy = vin[k].x >>> step;
      vout_next[k].neg = vin[k].neg;
      if (!vin[k].z[pfk_pkg::ZW-1]) begin
        vout_next[k].x = vin[k].x - dx;
        vout_next[k].y = vin[k].y + dy;
        vout_next[k].z = vin[k].z - atan;
      end else begin
        vout_next[k].x = vin[k].x + dx;
        vout_next[k].y = vin[k].y - dy;
        vout_next[k].z = vin[k].z + atan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    vout <= vout_next;
  end

endmodule

/* rtl/pfk_post.sv */
// ----------------------------------------------------------------------------
// pfk_post
// Back end: quadrant sign, sum of the three link vectors, rounding to q.14
// and saturation.
// ----------------------------------------------------------------------------
module pfk_post (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  pfk_pkg::vec3_t     vin,
  output logic               out_vld,
  output pfk_pkg::tip_word_t tip
);

  localparam int ACC_W     = pfk_pkg::CW + 2;
  localparam int FRAC_DROP = 16;
  localparam int RND_W     = ACC_W - FRAC_DROP;
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_DROP - 1);
  localparam logic signed [RND_W-1:0] SAT_MAX =
    RND_W'((1 << (pfk_pkg::OUT_W - 1)) - 1);
  localparam logic signed [RND_W-1:0] SAT_MIN = -(SAT_MAX + RND_W'(1));

  logic sum_vld;
  logic signed [ACC_W-1:0] acc_x, acc_y, acc_x_next, acc_y_next;
  pfk_pkg::tip_word_t tip_next;

  function automatic logic signed [pfk_pkg::OUT_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] r;
    logic signed [RND_W-1:0] v;
    r = acc + HALF_LSB;
    v = r[ACC_W-1:FRAC_DROP];
    if (v > SAT_MAX) begin
      v = SAT_MAX;
    end else if (v < SAT_MIN) begin
      v = SAT_MIN;
    end
    return v[pfk_pkg::OUT_W-1:0];
  endfunction

  always_comb begin
    acc_x_next = '0;
    acc_y_next = '0;
    for (int k = 0; k < pfk_pkg::LINKS; k++) begin
      if (vin[k].neg) begin
        acc_x_next = acc_x_next - ACC_W'(vin[k].x);
        acc_y_next = acc_y_next - ACC_W'(vin[k].y);
      end else begin
        acc_x_next = acc_x_next + ACC_W'(vin[k].x);
        acc_y_next = acc_y_next + ACC_W'(vin[k].y);
      end
    end
  end

  always_comb begin
    tip_next.tip_x = round_sat(acc_x);
    tip_next.tip_y = round_sat(acc_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      sum_vld <= in_vld;
      out_vld <= sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    acc_x <= acc_x_next;
    acc_y <= acc_y_next;
    tip   <= tip_next;
  end

endmodule

/* rtl/planar_three_link_forward_kinematics_unit.sv */
// ----------------------------------------------------------------------------
// planar_three_link_forward_kinematics_unit
// End-effector position of a planar three-link arm from its joint angles.
// ----------------------------------------------------------------------------
// A word of three joint angles is taken on any cycle where start is high and
// busy is low; busy is only high during reset, so one word can enter every
// cycle. Each word gives one tip position on the result port, marked by done
// for a single cycle, after it passes through the front end, the row of
// cordic cells, one micro-rotation per cell, and the back end. Results come
// out in order and cannot be held off, so the receiver must take done
// whenever it rises. The user must write link lengths through the cfg port
// only while no word is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module planar_three_link_forward_kinematics_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  pfk_pkg::joint_word_t joints,
  output logic                 done,
  output pfk_pkg::tip_word_t   tip,
  input  logic                 cfg_we,
  input  pfk_pkg::cfg_index_t  cfg_index,
  input  pfk_pkg::len_t        cfg_data
);

  localparam int STEPS = pfk_pkg::ROTATION_STEPS;

  pfk_pkg::len_t [pfk_pkg::LINKS-1:0] lens;
  logic [STEPS:0] chain_vld;
  pfk_pkg::vec3_t chain_vec [STEPS+1];
  logic in_vld;

  assign busy   = rst;
  assign in_vld = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      lens[0] <= pfk_pkg::FIRST_LINK_RESET;
      lens[1] <= pfk_pkg::SECOND_LINK_RESET;
      lens[2] <= pfk_pkg::TOOL_LINK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pfk_pkg::REG_FIRST_LINK:  lens[0] <= cfg_data;
        pfk_pkg::REG_SECOND_LINK: lens[1] <= cfg_data;
        pfk_pkg::REG_TOOL_LINK:   lens[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  pfk_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (in_vld),
    .joints  (joints),
    .lens    (lens),
    .out_vld (chain_vld[0]),
    .vec     (chain_vec[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    pfk_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .step    (pfk_pkg::STEP_W'(i)),
      .atan    (pfk_pkg::ATAN_Q28[i]),
      .in_vld  (chain_vld[i]),
      .vin     (chain_vec[i]),
      .out_vld (chain_vld[i+1]),
      .vout    (chain_vec[i+1])
    );
  end

  pfk_post u_post (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (chain_vld[STEPS]),
    .vin     (chain_vec[STEPS]),
    .out_vld (done),
    .tip     (tip)
  );

endmodule
